/* hw/rtl/tsm_pkg.sv */
// Shared types and constants for the tachometer speed meter.
// No dependencies; the files that use it refer to it by scoped names.
package tsm_pkg;

	localparam int MAX_REPORTED = 3;
	localparam int COUNT_W      = 16;
	localparam int TIME_W       = 32;
	localparam int CLOCK_W      = 27;
	localparam int RPM_W        = 32;
	localparam int CHAN_W       = 2;
	localparam int DIVIDEND_W   = 33;
	localparam int DIVISOR_W    = 32;
	localparam int STEP_W       = 6;

	localparam logic                OP_SAMPLE          = 1'b0;
	localparam logic                OP_REPORT          = 1'b1;
	localparam logic [COUNT_W-1:0]  COUNT_MAX          = 16'hFFFF;
	localparam logic [COUNT_W-1:0]  MIN_EDGES          = 16'd2;
	localparam logic [CLOCK_W-1:0]  CLOCK_RESET        = 27'd7372800;
	localparam logic [5:0]          SECONDS_PER_MINUTE = 6'd60;

	// per-channel snapshot taken by a report
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  span;
	} chan_snap_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  channel;
		logic [COUNT_W-1:0] edge_count;
		logic [RPM_W-1:0]   rpm;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/tsm_fifo.sv */
// Small register-based FIFO with show-ahead read.
// Used for the report job queue and the result queue; no dependencies.
module tsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/tsm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on tsm_pkg for widths and the request/response structs.
module tsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tsm_pkg::div_req_t req,
	output tsm_pkg::div_rsp_t rsp
);
	logic [tsm_pkg::DIVISOR_W-1:0]  rem_q, divisor_q;
	logic [tsm_pkg::DIVIDEND_W-1:0] quo_q;
	logic [tsm_pkg::STEP_W-1:0]     step_q;
	logic                           busy_q, done_q;
	logic [tsm_pkg::DIVISOR_W:0]    shifted, diff;
	logic                           ge;

	always_comb begin
		shifted = {rem_q, quo_q[tsm_pkg::DIVIDEND_W-1]};
		ge      = (shifted >= {1'b0, divisor_q});
		diff    = shifted - {1'b0, divisor_q};
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + tsm_pkg::STEP_W'(1);
				if (step_q == tsm_pkg::STEP_W'(tsm_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tsm_pkg::DIVISOR_W-1:0] : shifted[tsm_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[tsm_pkg::DIVIDEND_W-2:0], ge};
		end
	end

endmodule

/* hw/rtl/tsm_front.sv */
// Front end: takes sample and report transactions, tracks edges per channel
// and hands report snapshots to the job queue. Depends on tsm_pkg.
module tsm_front #(
	parameter int ACTIVE = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  operation,
	input  logic [tsm_pkg::TIME_W-1:0]            timestamp,
	input  logic [2:0]                            pin_levels,
	output logic                                  job_push,
	output tsm_pkg::chan_snap_t [ACTIVE-1:0]      job_data,
	input  logic                                  job_full
);
	logic accept, sample_acc, report_acc;

	logic                           prev_q  [ACTIVE];
	logic [tsm_pkg::COUNT_W-1:0]    cnt_q   [ACTIVE];
	logic [tsm_pkg::TIME_W-1:0]     first_q [ACTIVE];
	logic [tsm_pkg::TIME_W-1:0]     last_q  [ACTIVE];
	logic [ACTIVE-1:0]              rise;

	assign full       = job_full;
	assign accept     = push & ~job_full;
	assign sample_acc = accept & (operation == tsm_pkg::OP_SAMPLE);
	assign report_acc = accept & (operation == tsm_pkg::OP_REPORT);
	assign job_push   = report_acc;

	for (genvar c = 0; c < ACTIVE; c++) begin : g_chan
		// saturated counters ignore further edges, latest time included
		assign rise[c] = pin_levels[c] & ~prev_q[c] & (cnt_q[c] != tsm_pkg::COUNT_MAX);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				prev_q[c] <= 1'b0;
				cnt_q[c]  <= '0;
			end else if (report_acc) begin
				prev_q[c] <= 1'b0;
				cnt_q[c]  <= '0;
			end else if (sample_acc) begin
				prev_q[c] <= pin_levels[c];
				if (rise[c]) begin
					cnt_q[c] <= cnt_q[c] + tsm_pkg::COUNT_W'(1);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (sample_acc && rise[c]) begin
				if (cnt_q[c] == '0) begin
					first_q[c] <= timestamp;
				end
				last_q[c] <= timestamp;
			end
		end

		assign job_data[c].count = cnt_q[c];
		assign job_data[c].span  = last_q[c] - first_q[c];
	end

endmodule

/* hw/rtl/tsm_back.sv */
// Back end: turns each report snapshot into per-channel results, using one
// shared divider for the mean period and the rpm. Depends on tsm_pkg, tsm_div.
module tsm_back #(
	parameter int ACTIVE = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tsm_pkg::CLOCK_W-1:0]        clock_hz,
	input  logic                               job_empty,
	output logic                               job_pop,
	input  tsm_pkg::chan_snap_t [ACTIVE-1:0]   job_data,
	output logic                               res_push,
	output tsm_pkg::result_t                   res_data,
	input  logic                               res_full
);
	localparam int CW = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_DIV1, ST_DIV2, ST_EMIT} state_t;

	state_t                            state_q;
	tsm_pkg::chan_snap_t [ACTIVE-1:0]  job_q;
	logic [CW-1:0]                     ch_q;
	logic [tsm_pkg::RPM_W-1:0]         rpm_q;
	tsm_pkg::chan_snap_t               cur;
	tsm_pkg::div_req_t                 div_req;
	tsm_pkg::div_rsp_t                 div_rsp;
	logic [tsm_pkg::DIVIDEND_W-1:0]    clk60;
	logic                              last_ch;

	tsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cur     = job_q[ch_q];
	assign last_ch = (ch_q == CW'(ACTIVE - 1));
	assign clk60   = tsm_pkg::DIVIDEND_W'(clock_hz)
	               * tsm_pkg::DIVIDEND_W'(tsm_pkg::SECONDS_PER_MINUTE);
	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_EMIT) && !res_full;

	always_comb begin
		res_data.channel     = tsm_pkg::CHAN_W'(ch_q);
		res_data.edge_count  = cur.count;
		res_data.rpm         = rpm_q;
		res_data.last_of_run = last_ch;
	end

	always_comb begin
		div_req = '0;
		if (state_q == ST_LOAD && cur.count >= tsm_pkg::MIN_EDGES) begin
			div_req.start    = 1'b1;
			div_req.dividend = {1'b0, cur.span};
			div_req.divisor  = {16'b0, cur.count - tsm_pkg::COUNT_W'(1)};
		end else if (state_q == ST_DIV1 && div_rsp.done
		             && div_rsp.quotient[tsm_pkg::DIVISOR_W-1:0] != '0) begin
			div_req.start    = 1'b1;
			div_req.dividend = clk60;
			div_req.divisor  = div_rsp.quotient[tsm_pkg::DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			rpm_q   <= '0;
			job_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						job_q   <= job_data;
						ch_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cur.count < tsm_pkg::MIN_EDGES) begin
						rpm_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient[tsm_pkg::DIVISOR_W-1:0] == '0) begin
							rpm_q   <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV2;
						end
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						// quotient above 32 bits saturates
						rpm_q <= div_rsp.quotient[tsm_pkg::DIVIDEND_W-1]
						       ? '1 : div_rsp.quotient[tsm_pkg::RPM_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + CW'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/tachometer_speed_meter.sv */
// Tachometer speed meter, top level.
// Depends on tsm_pkg, tsm_fifo, tsm_front, tsm_back (and tsm_div below it).
//
// Input queue side: push/full with operation, timestamp, pin_levels. A sample
// transaction updates edge counts and edge times in the cycle it is taken, so
// samples go in one per cycle while full is low. A report snapshots every
// channel, clears the channel state (pin levels included) and queues the
// snapshot in a two-entry job queue; full rises only while it holds two reports.
// Result queue side: empty/pop with channel, edge_count, rpm, last_of_run;
// one transaction per channel, channel 0 first, last_of_run on the final one.
// Each channel of a report runs the shared one-bit-per-cycle divider up to
// twice (mean period, then rpm when that period is nonzero); channels
// with an edge count below two skip it. Results wait in a four-entry
// queue; when the receiver stalls the back end holds and, once the job queue
// fills, full stops input. Samples keep flowing while a report is computed.
// Configuration: cfg_valid/cfg_ready/cfg_data writes clock_hz, always ready.
// Reset clears edge counts, pin levels and queues and sets clock_hz to 7372800.
module tachometer_speed_meter #(
	parameter int CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [31:0] timestamp,
	input  logic [2:0]  pin_levels,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  channel,
	output logic [15:0] edge_count,
	output logic [31:0] rpm,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [26:0] cfg_data
);
	localparam int ACTIVE = (CHANNELS < tsm_pkg::MAX_REPORTED) ? CHANNELS
	                      : tsm_pkg::MAX_REPORTED;
	localparam int JOB_W  = ACTIVE * $bits(tsm_pkg::chan_snap_t);

	logic [tsm_pkg::CLOCK_W-1:0]       clock_hz_q;
	logic                              job_push, job_full, job_pop, job_empty;
	tsm_pkg::chan_snap_t [ACTIVE-1:0]  job_wdata, job_rdata;
	logic                              res_push, res_full;
	tsm_pkg::result_t                  res_wdata, res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= tsm_pkg::CLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clock_hz_q <= cfg_data;
		end
	end

	tsm_front #(.ACTIVE(ACTIVE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.timestamp  (timestamp),
		.pin_levels (pin_levels),
		.job_push   (job_push),
		.job_data   (job_wdata),
		.job_full   (job_full)
	);

	tsm_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	tsm_back #(.ACTIVE(ACTIVE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clock_hz  (clock_hz_q),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job_data  (job_rdata),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.res_full  (res_full)
	);

	tsm_fifo #(.WIDTH($bits(tsm_pkg::result_t)), .DEPTH(4)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign channel     = res_rdata.channel;
	assign edge_count  = res_rdata.edge_count;
	assign rpm         = res_rdata.rpm;
	assign last_of_run = res_rdata.last_of_run;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_of_run == (channel == 2'(ACTIVE - 1))))
		else $error("last_of_run not on the final channel");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (channel <= 2'(ACTIVE - 1)))
		else $error("result channel out of range");

	a_rpm_few_edges: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && edge_count < tsm_pkg::MIN_EDGES) |-> (rpm == '0))
		else $error("nonzero rpm with fewer than two edges");

endmodule

/* tb/tsm_checker.sv */
// Scoreboard for the tachometer speed meter: tracks input and result transactions,
// predicts per-channel edge counts and rpm, and compares every result in order.
// Depends on tsm_pkg for field widths, operation codes and the result struct.
module tsm_checker #(
	parameter int CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        operation,
	input  logic [31:0] timestamp,
	input  logic [2:0]  pin_levels,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  channel,
	input  logic [15:0] edge_count,
	input  logic [31:0] rpm,
	input  logic        last_of_run,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [26:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam int ACTIVE = (CHANNELS < tsm_pkg::MAX_REPORTED) ? CHANNELS
		: tsm_pkg::MAX_REPORTED;

	logic [tsm_pkg::CLOCK_W-1:0] tick_hz;
	logic                        level_was [ACTIVE];
	logic [tsm_pkg::COUNT_W-1:0] edges [ACTIVE];
	logic [tsm_pkg::TIME_W-1:0]  first_edge [ACTIVE];
	logic [tsm_pkg::TIME_W-1:0]  latest_edge [ACTIVE];
	tsm_pkg::result_t            speed_reports [$];

	function automatic void clear_channels();
		for (int c = 0; c < ACTIVE; c++) begin
			level_was[c] = 1'b0;
			edges[c] = '0;
			first_edge[c] = '0;
			latest_edge[c] = '0;
		end
	endfunction

	// mean period over count-1 intervals, then ticks per minute over that period
	function automatic logic [31:0] rpm_for(int c);
		logic [31:0] span;
		logic [31:0] period;
		logic [63:0] quot;
		if (edges[c] < tsm_pkg::MIN_EDGES)
			return '0;
		span = latest_edge[c] - first_edge[c];
		period = span / (32'(edges[c]) - 32'd1);
		if (period == 0)
			return '0;
		quot = (64'(tick_hz) * 64'(tsm_pkg::SECONDS_PER_MINUTE)) / 64'(period);
		return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tsm_pkg::result_t got;
		tsm_pkg::result_t want;
		logic lvl;
		if (!arst_n) begin
			tick_hz = tsm_pkg::CLOCK_RESET;
			clear_channels();
			speed_reports.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tick_hz = cfg_data;

			// results are checked before this edge's input can add expectations
			if (pop && !empty) begin
				got.channel = channel;
				got.edge_count = edge_count;
				got.rpm = rpm;
				got.last_of_run = last_of_run;
				if (speed_reports.size() == 0) begin
					$error("unexpected result: channel %0d edge_count %0d rpm %0d",
						channel, edge_count, rpm);
					mismatches++;
				end else begin
					want = speed_reports.pop_front();
					if (got.channel !== want.channel) begin
						$error("channel: expected %0d, got %0d", want.channel, got.channel);
						mismatches++;
					end
					if (got.edge_count !== want.edge_count) begin
						$error("edge_count: expected %0d, got %0d",
							want.edge_count, got.edge_count);
						mismatches++;
					end
					if (got.rpm !== want.rpm) begin
						$error("rpm: expected %0d, got %0d", want.rpm, got.rpm);
						mismatches++;
					end
					if (got.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want.last_of_run, got.last_of_run);
						mismatches++;
					end
				end
			end

			if (push && !full) begin
				if (operation == tsm_pkg::OP_SAMPLE) begin
					for (int c = 0; c < ACTIVE; c++) begin
						lvl = pin_levels[c];
						// saturated count freezes latest edge time too
						if (lvl && !level_was[c] && edges[c] != tsm_pkg::COUNT_MAX) begin
							if (edges[c] == 0)
								first_edge[c] = timestamp;
							latest_edge[c] = timestamp;
							edges[c] = edges[c] + 1'b1;
						end
						level_was[c] = lvl;
					end
				end else begin
					for (int c = 0; c < ACTIVE; c++) begin
						want.channel = 2'(c);
						want.edge_count = edges[c];
						want.rpm = rpm_for(c);
						want.last_of_run = (c == ACTIVE - 1);
						speed_reports.push_back(want);
					end
					clear_channels();
				end
			end

			pending <= speed_reports.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the tachometer speed meter testbench: clock, reset, stimulus and verdict.
// Depends on tsm_pkg, the tachometer_speed_meter RTL and tsm_checker.
module testbench;

	localparam int RUN_LIMIT = 1_000_000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        operation = tsm_pkg::OP_SAMPLE;
	logic [31:0] timestamp = '0;
	logic [2:0]  pin_levels = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  channel;
	logic [15:0] edge_count;
	logic [31:0] rpm;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [26:0] cfg_data = '0;

	int mismatches;
	int pending;
	int send_idle = 0;
	int pop_idle = 0;
	int items_sent = 0;
	int clock_pick = 0;
	int cycle_count = 0;

	tachometer_speed_meter #(.CHANNELS(3)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .timestamp(timestamp), .pin_levels(pin_levels),
		.empty(empty), .pop(pop),
		.channel(channel), .edge_count(edge_count), .rpm(rpm), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tsm_checker #(.CHANNELS(3)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .timestamp(timestamp), .pin_levels(pin_levels),
		.empty(empty), .pop(pop),
		.channel(channel), .edge_count(edge_count), .rpm(rpm), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("** tachometer_speed_meter: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_idle);
	end

	task automatic send_item(input logic op, input logic [31:0] ts, input logic [2:0] pins);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		timestamp <= ts;
		pin_levels <= pins;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_report();
		send_item(tsm_pkg::OP_REPORT, $urandom, 3'($urandom_range(7)));
	endtask

	// all results in, then a short pause for any sample still in flight
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_clock(input logic [26:0] hz);
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one measurement window: mostly rising timestamps, pins pulsing, then usually a report
	task automatic random_window();
		int n;
		logic [31:0] ts;
		logic [31:0] step_max;
		bit scramble;
		n = $urandom_range(16, 2);
		ts = $urandom;
		scramble = ($urandom_range(9) == 0);
		case ($urandom_range(4))
			0: step_max = 32'd1;
			1: step_max = 32'd8;
			2: step_max = 32'd1000;
			3: step_max = 32'd200000;
			default: step_max = 32'h0100_0000;
		endcase
		for (int i = 0; i < n; i++) begin
			ts += $urandom_range(step_max, 0);
			if (scramble)
				send_item(tsm_pkg::OP_SAMPLE, $urandom, 3'($urandom_range(7)));
			else if (i[0])
				send_item(tsm_pkg::OP_SAMPLE, ts,
					($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b111);
			else
				send_item(tsm_pkg::OP_SAMPLE, ts, 3'b000);
		end
		// now and then the window runs on into the next one
		if ($urandom_range(7) != 0)
			send_report();
	endtask

	task automatic run_phase(input int target);
		int start;
		int windows;
		start = items_sent;
		windows = 0;
		while (items_sent - start < target) begin
			if (windows % 4 == 0) begin
				drain();
				case (clock_pick % 6)
					0: write_clock(27'd1);
					1: write_clock(27'd0);
					2: write_clock(27'h7FF_FFFF);
					3: write_clock(tsm_pkg::CLOCK_RESET);
					4: write_clock(27'd100_000_000);
					default: write_clock(27'($urandom_range(100_000_000, 1)));
				endcase
				clock_pick++;
			end
			random_window();
			windows++;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 20;
		pop_idle <= 84;

		// report on empty state, ignored fields at their extremes
		send_item(tsm_pkg::OP_REPORT, 32'hFFFF_FFFF, 3'b111);
		// plain windows, one channel left with a single edge
		send_item(tsm_pkg::OP_SAMPLE, 32'd0, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd1000, 3'b111);
		send_item(tsm_pkg::OP_SAMPLE, 32'd1500, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd3000, 3'b011);
		send_item(tsm_pkg::OP_SAMPLE, 32'd3100, 3'b001);
		send_report();
		// pins held high across a report count again afterwards
		send_item(tsm_pkg::OP_SAMPLE, 32'd10, 3'b111);
		send_report();
		send_item(tsm_pkg::OP_SAMPLE, 32'd20, 3'b111);
		send_item(tsm_pkg::OP_SAMPLE, 32'd21, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd20, 3'b111);
		send_report();
		// edge times straddling the timestamp wrap
		send_item(tsm_pkg::OP_SAMPLE, 32'hFFFF_FFF0, 3'b111);
		send_item(tsm_pkg::OP_SAMPLE, 32'h0000_0000, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'h0000_0010, 3'b111);
		send_report();
		// edge count of three with an edge-time span of 1: mean period rounds to zero
		send_item(tsm_pkg::OP_SAMPLE, 32'd5, 3'b001);
		send_item(tsm_pkg::OP_SAMPLE, 32'd0, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd6, 3'b001);
		send_item(tsm_pkg::OP_SAMPLE, 32'd0, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd6, 3'b001);
		send_report();
		// a 100 MHz clock over a one-tick period overflows rpm
		drain();
		write_clock(27'd100_000_000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd0, 3'b111);
		send_item(tsm_pkg::OP_SAMPLE, 32'd0, 3'b000);
		send_item(tsm_pkg::OP_SAMPLE, 32'd1, 3'b111);
		send_report();

		run_phase(42);

		send_idle = 84;
		pop_idle <= 20;
		run_phase(42);

		send_idle = 0;
		pop_idle <= 0;
		run_phase(42);

		drain();
		repeat (250) @(posedge clk);
		if (mismatches == 0)
			$display("** tachometer_speed_meter: PASSED **");
		else
			$display("** tachometer_speed_meter: FAILED **");
		$finish;
	end

endmodule
